// ===== rtl/pbo_pkg.sv =====
// shared types and constants for the pulse/blink output channel
// no dependencies; imported by every other file of the block
package pbo_pkg;

    localparam int DW = 32;

    localparam logic [1:0] MODE_STEADY = 2'd0;
    localparam logic [1:0] MODE_PULSE  = 2'd1;
    localparam logic [1:0] MODE_BLINK  = 2'd2;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_PULSE_LEN = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;
    localparam logic [1:0] REG_ON_TIME   = 2'd3;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [DW-1:0] ON_TIME_RST = 32'd65535;

    typedef struct packed {
        logic [1:0]    mode;
        logic [DW-1:0] pulse_len;
        logic [DW-1:0] period;
        logic [DW-1:0] on_time;
    } t_cfg;

endpackage

// ===== rtl/pbo_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on pbo_pkg
interface pbo_item_if;
    import pbo_pkg::*;
    logic          valid;
    logic          ready;
    logic          kind;
    logic [DW-1:0] now_ms;
    logic          level;
    modport source (output valid, kind, now_ms, level, input ready);
    modport sink   (input valid, kind, now_ms, level, output ready);
endinterface

interface pbo_result_if;
    logic valid;
    logic ready;
    logic drive;
    logic active;
    modport source (output valid, drive, active, input ready);
    modport sink   (input valid, drive, active, output ready);
endinterface

// ===== rtl/pulse_blink_output_channel.sv =====
// pulse/blink output channel: steady, one-shot pulse and blink pattern modes
// writes and ticks outside blink-with-period go straight to the result register; a blink tick
// with nonzero period runs the remainder unit (32 serial remainder steps) in S_DIV, then S_FIN registers
// the result; one item per cycle while idle and the result slot is free (input held in S_DIV/S_FIN)
// sync active-low reset clears control/output state, not r_now or divider data; on-time resets to 65535, others to 0
// depends on pbo_pkg, pbo_if, pbo_cfg, pbo_rem
module pulse_blink_output_channel (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pbo_item_if.sink               i_item,
    pbo_result_if.source           o_result,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [pbo_pkg::DW-1:0] i_cfg_data
);
    import pbo_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} t_state;

    t_state        r_state, n_state;
    logic          r_req, n_req;
    logic [DW-1:0] r_ps, n_ps;
    logic [DW-1:0] r_anchor, n_anchor;
    logic          r_drive, n_drive;
    logic [DW-1:0] r_now, n_now;
    logic          r_out_valid, n_out_valid;
    logic          r_out_drive, n_out_drive;
    logic          r_out_active, n_out_active;

    t_cfg          w_cfg;
    logic          w_period_wr;
    logic          w_ready;
    logic          w_acc;
    logic          w_start;
    logic [DW-1:0] w_dividend;
    logic          w_rem_done;
    logic [DW-1:0] w_rem;
    logic          w_slot_free;

    pbo_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_period_wr (w_period_wr)
    );

    pbo_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_cfg.period),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    assign w_slot_free = !r_out_valid || o_result.ready;
    assign w_ready     = (r_state == S_IDLE) && w_slot_free;
    assign w_acc       = w_ready && i_item.valid;

    always_comb begin
        logic          v_req;
        logic [DW-1:0] v_ps;
        logic [DW-1:0] v_anchor;
        logic          v_on;
        logic [DW:0]   v_end;

        n_state      = r_state;
        n_req        = r_req;
        n_ps         = r_ps;
        n_anchor     = r_anchor;
        n_drive      = r_drive;
        n_now        = r_now;
        n_out_valid  = r_out_valid;
        n_out_drive  = r_out_drive;
        n_out_active = r_out_active;
        w_start      = 1'b0;
        v_req        = r_req;
        v_ps         = r_ps;
        v_anchor     = r_anchor;
        v_on         = 1'b0;
        v_end        = {1'b0, r_ps} + {1'b0, w_cfg.pulse_len};
        w_dividend   = i_item.now_ms - r_anchor;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_item.kind == KIND_WRITE) begin
                        if (w_cfg.mode == MODE_PULSE && w_cfg.pulse_len != '0
                                && !i_item.level) begin
                            v_ps = '0;
                        end
                        n_req        = i_item.level;
                        n_ps         = v_ps;
                        n_out_valid  = 1'b1;
                        n_out_drive  = r_drive;
                        n_out_active = (w_cfg.mode == MODE_PULSE) ? (v_ps != '0)
                                                                  : i_item.level;
                    end else begin
                        if (w_cfg.mode == MODE_PULSE) begin
                            if (v_req) begin
                                v_ps  = i_item.now_ms;
                                v_req = 1'b0;
                            end
                            // end time kept at 33 bits so it never wraps
                            v_end = {1'b0, v_ps} + {1'b0, w_cfg.pulse_len};
                            if (v_ps != '0 && {1'b0, i_item.now_ms} < v_end) begin
                                v_on = 1'b1;
                            end else begin
                                v_ps = '0;
                            end
                        end
                        if (v_req) begin
                            if (w_cfg.mode == MODE_BLINK) begin
                                if (v_anchor == '0) begin
                                    v_anchor = i_item.now_ms;
                                end
                                if (w_cfg.period == '0) begin
                                    v_on = 1'b1;
                                end
                            end else begin
                                v_on = 1'b1;
                            end
                        end
                        n_req      = v_req;
                        n_ps       = v_ps;
                        n_anchor   = v_anchor;
                        w_dividend = i_item.now_ms - v_anchor;
                        if (v_req && w_cfg.mode == MODE_BLINK && w_cfg.period != '0) begin
                            w_start = 1'b1;
                            n_now   = i_item.now_ms;
                            n_state = S_DIV;
                        end else begin
                            n_drive      = v_on;
                            n_out_valid  = 1'b1;
                            n_out_drive  = v_on;
                            n_out_active = (w_cfg.mode == MODE_PULSE) ? (v_ps != '0)
                                                                      : v_req;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    // realigned anchor is now minus the phase within the period
                    n_anchor     = r_now - w_rem;
                    n_drive      = w_rem < w_cfg.on_time;
                    n_out_valid  = 1'b1;
                    n_out_drive  = w_rem < w_cfg.on_time;
                    n_out_active = r_req;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_period_wr) begin
            n_anchor = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_req        <= 1'b0;
            r_ps         <= '0;
            r_anchor     <= '0;
            r_drive      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_drive  <= 1'b0;
            r_out_active <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_req        <= n_req;
            r_ps         <= n_ps;
            r_anchor     <= n_anchor;
            r_drive      <= n_drive;
            r_out_valid  <= n_out_valid;
            r_out_drive  <= n_out_drive;
            r_out_active <= n_out_active;
        end
        r_now <= n_now;
    end

    assign i_item.ready    = w_ready;
    assign o_result.valid  = r_out_valid;
    assign o_result.drive  = r_out_drive;
    assign o_result.active = r_out_active;

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("item taken while result stalled");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_done |-> (r_state == S_DIV))
        else $error("remainder done outside divide state");

    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_DIV))
        else $error("divide start did not enter divide state");

    a_div_leaves_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_FIN))
        else $error("divide state left early");

endmodule

// ===== rtl/pbo_cfg.sv =====
// configuration register file: mode, pulse length, blink period and on-time
// depends on pbo_pkg
module pbo_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [pbo_pkg::DW-1:0] i_cfg_data,
    output pbo_pkg::t_cfg         o_cfg,
    output logic                  o_period_wr
);
    import pbo_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_STEADY;
            r_cfg.pulse_len <= '0;
            r_cfg.period    <= '0;
            r_cfg.on_time   <= ON_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:      r_cfg.mode      <= i_cfg_data[1:0];
                REG_PULSE_LEN: r_cfg.pulse_len <= i_cfg_data;
                REG_PERIOD:    r_cfg.period    <= i_cfg_data;
                REG_ON_TIME:   r_cfg.on_time   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg       = r_cfg;
    assign o_period_wr = i_cfg_we && (i_cfg_idx == REG_PERIOD);

endmodule

// ===== rtl/pbo_rem.sv =====
// bit-serial restoring remainder unit, one quotient bit per cycle
// depends on pbo_pkg
module pbo_rem (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [pbo_pkg::DW-1:0] i_dividend,
    input  logic [pbo_pkg::DW-1:0] i_divisor,
    output logic                   o_done,
    output logic [pbo_pkg::DW-1:0] o_rem
);
    import pbo_pkg::*;

    localparam int CW = $clog2(DW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvd, n_dvd;
    logic [DW-1:0] r_dsr, n_dsr;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;

    // shared subtract/compare: shift in next dividend bit, try the divisor
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_diff[DW] ? w_trial[DW-1:0] : w_diff[DW-1:0];
            n_dvd = {r_dvd[DW-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
